// ===== hdl/bht_pkg.sv =====
package bht_pkg;

	// table geometry
	localparam int unsigned ENTRY_COUNT = 4096;

	// field widths
	localparam int unsigned INDEX_W = 12;
	localparam int unsigned DIST_W  = 6;
	localparam int unsigned REF_W   = 16;
	localparam int unsigned POS_W   = 32;
	localparam int unsigned BEST_W  = 7;
	localparam int unsigned COUNT_W = 11;

	// count saturation point
	localparam logic [COUNT_W-1:0] COUNT_CEILING = 11'd1024;

	// index reduction: compare-subtract steps per cycle and cycles needed
	localparam int unsigned RED_STEPS  = 4;
	localparam int unsigned RED_CYCLES = INDEX_W / RED_STEPS;

	// action codes
	localparam logic ACT_MATCH = 1'b0;
	localparam logic ACT_READ  = 1'b1;

	// register indexes
	localparam logic [1:0] REG_NEAR_WINDOW   = 2'd0;
	localparam logic [1:0] REG_MIN_DISTANCE  = 2'd1;
	localparam logic [1:0] REG_MAX_BEST_HITS = 2'd2;

	// register reset values
	localparam logic [7:0] NEAR_WINDOW_RST   = 8'd18;
	localparam logic [5:0] MIN_DISTANCE_RST  = 6'd2;
	localparam logic [9:0] MAX_BEST_HITS_RST = 10'd10;

	// one queued item, index already reduced into the table range
	typedef struct packed {
		logic               action;
		logic [INDEX_W-1:0] fragment_index;
		logic [DIST_W-1:0]  hit_distance;
		logic [REF_W-1:0]   reference_id;
		logic               reverse_strand;
		logic [POS_W-1:0]   hit_position;
	} item_t;

	// one table entry; last hit fields only meaningful once best is set
	typedef struct packed {
		logic [BEST_W-1:0]  best;
		logic [COUNT_W-1:0] count;
		logic               enabled;
		logic               last_strand;
		logic [REF_W-1:0]   last_reference;
		logic [POS_W-1:0]   last_position;
	} entry_t;

	localparam entry_t ENTRY_RESET = '{
		best:           7'h7F,
		count:          '0,
		enabled:        1'b1,
		last_strand:    1'b0,
		last_reference: '0,
		last_position:  '0
	};

	// configuration handed to the back end
	typedef struct packed {
		logic [7:0] near_window;
		logic [5:0] min_distance;
		logic [9:0] max_best_hits;
	} cfg_t;

	// back end status seen by the top level
	typedef struct packed {
		logic clearing;
	} back_status_t;

endpackage

// ===== hdl/bht_front.sv =====
module bht_front #(
	parameter int unsigned ENTRY_COUNT = bht_pkg::ENTRY_COUNT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  enable,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  bht_pkg::item_t        in_item,
	output logic                  q_valid,
	output bht_pkg::item_t        q_item,
	input  logic                  q_pop
);

	localparam logic [31:0] N_W = 32'(ENTRY_COUNT);

	// hold register where the index is reduced into the table range
	logic           hold_valid_q;
	bht_pkg::item_t hold_q;
	logic [1:0]     red_cyc_q;
	logic [31:0]    red_v;
	logic           in_range;
	logic           push;

	// small queue toward the back end
	bht_pkg::item_t fifo_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     fill_q;

	assign in_ready = enable && !hold_valid_q;
	assign in_range = {20'd0, hold_q.fragment_index} < N_W;
	assign push     = hold_valid_q && in_range && (fill_q != 2'd2);

	// several restoring compare-subtract steps per cycle
	always_comb begin
		int k;
		red_v = {20'd0, hold_q.fragment_index};
		for (int j = 0; j < int'(bht_pkg::RED_STEPS); j++) begin
			k = int'(bht_pkg::INDEX_W) - 1 - int'(bht_pkg::RED_STEPS) * int'(red_cyc_q) - j;
			if (k >= 0) begin
				if (red_v >= (N_W << k)) begin
					red_v = red_v - (N_W << k);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			red_cyc_q    <= '0;
		end else if (in_valid && in_ready) begin
			hold_valid_q <= 1'b1;
			red_cyc_q    <= '0;
		end else if (push) begin
			hold_valid_q <= 1'b0;
		end else if (hold_valid_q && !in_range) begin
			red_cyc_q <= red_cyc_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			hold_q <= in_item;
		end else if (hold_valid_q && !in_range) begin
			hold_q.fragment_index <= red_v[bht_pkg::INDEX_W-1:0];
		end
	end

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, q_pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= hold_q;
		end
	end

	assign q_valid = fill_q != 2'd0;
	assign q_item  = fifo_q[rd_ptr_q];

endmodule

// ===== hdl/bht_back.sv =====
module bht_back #(
	parameter int unsigned ENTRY_COUNT = bht_pkg::ENTRY_COUNT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bht_pkg::cfg_t          cfg,
	input  logic                   q_valid,
	input  bht_pkg::item_t         q_item,
	output logic                   q_pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [bht_pkg::BEST_W-1:0]  out_best,
	output logic [bht_pkg::COUNT_W-1:0] out_count,
	output logic                   out_enabled,
	output bht_pkg::back_status_t  status
);

	localparam int unsigned AW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRY_COUNT - 1);
	localparam int unsigned ENTRY_W = $bits(bht_pkg::entry_t);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_EXEC  = 2'd2;

	logic [1:0]      state_q;
	logic [AW-1:0]   clr_addr_q;
	logic [ENTRY_W-1:0] mem [ENTRY_COUNT];

	bht_pkg::item_t  item_s1;
	bht_pkg::entry_t rd_s1;
	bht_pkg::entry_t upd;
	logic [AW-1:0]   addr_s1;
	logic [AW-1:0]   pop_addr;
	logic [AW+bht_pkg::INDEX_W-1:0] idx_ext;

	logic            out_free;
	logic            exec_done;
	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	logic [ENTRY_W-1:0] mem_wdata;

	logic            out_valid_q;
	bht_pkg::entry_t out_q;

	// update logic
	logic signed [bht_pkg::BEST_W-1:0] best_v;
	logic signed [bht_pkg::BEST_W-1:0] dist_v;
	logic signed [bht_pkg::POS_W:0]    pos_diff;
	logic            same_place;
	logic            near;
	logic            is_equal;
	logic            is_better;
	logic [bht_pkg::COUNT_W-1:0] count_inc;

	assign idx_ext  = {{AW{1'b0}}, q_item.fragment_index};
	assign pop_addr = idx_ext[AW-1:0];
	assign out_free = !out_valid_q || out_ready;
	assign q_pop    = (state_q == ST_IDLE) && q_valid;
	assign exec_done = (state_q == ST_EXEC) && out_free;

	assign best_v   = $signed(rd_s1.best);
	assign dist_v   = $signed({1'b0, item_s1.hit_distance});
	assign pos_diff = $signed({1'b0, item_s1.hit_position}) -
	                  $signed({1'b0, rd_s1.last_position});
	assign same_place = (rd_s1.last_reference == item_s1.reference_id) &&
	                    (rd_s1.last_strand == item_s1.reverse_strand);
	assign near      = same_place && (pos_diff < $signed({25'd0, cfg.near_window}));
	assign is_equal  = best_v == dist_v;
	assign is_better = (best_v == -7'sd1) || (dist_v < best_v);
	assign count_inc = (rd_s1.count < bht_pkg::COUNT_CEILING) ?
	                   rd_s1.count + 11'd1 : rd_s1.count;

	// read-modify-write of the addressed entry
	always_comb begin
		upd = rd_s1;
		if (item_s1.action == bht_pkg::ACT_MATCH && rd_s1.enabled) begin
			if (is_equal) begin
				if (!near) begin
					upd.count          = count_inc;
					upd.enabled        = !(count_inc > {1'b0, cfg.max_best_hits});
					upd.last_strand    = item_s1.reverse_strand;
					upd.last_reference = item_s1.reference_id;
					upd.last_position  = item_s1.hit_position;
				end
			end else if (is_better) begin
				upd.best           = {1'b0, item_s1.hit_distance};
				upd.count          = 11'd1;
				upd.enabled        = !(item_s1.hit_distance < cfg.min_distance);
				upd.last_strand    = item_s1.reverse_strand;
				upd.last_reference = item_s1.reference_id;
				upd.last_position  = item_s1.hit_position;
			end
		end
	end

	// sequencer: clearing pass, then pop / execute
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item and entry read stage
	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_s1 <= q_item;
			addr_s1 <= pop_addr;
			rd_s1   <= mem[pop_addr];
		end
	end

	// single write port shared by clearing and updates
	assign mem_we    = (state_q == ST_CLEAR) || exec_done;
	assign mem_waddr = (state_q == ST_CLEAR) ? clr_addr_q : addr_s1;
	assign mem_wdata = (state_q == ST_CLEAR) ? bht_pkg::ENTRY_RESET : upd;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_done) begin
			out_q <= upd;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_best        = out_q.best;
	assign out_count       = out_q.count;
	assign out_enabled     = out_q.enabled;
	assign status.clearing = state_q == ST_CLEAR;

endmodule

// ===== hdl/best_hit_tracker_table.sv =====
// Best-hit tracker table. Each stream item either reports a match for one
// fragment (tuser = 0) or reads that fragment's statistics (tuser = 1), and
// every item returns exactly one result: best distance (-1 when none), count
// of best hits and the enabled flag, as they stand after the item. After
// reset the table is swept back to its initial values over all ENTRY_COUNT
// entries (4096 by default); s_tready stays low during the sweep, while the
// register port works as usual. An item's entry is then read in the idle
// state and updated and written back in the execute state, which waits until
// the previous result is taken; no new item is popped before the write-back.
// When ENTRY_COUNT is below 4096, an index at or above ENTRY_COUNT is reduced
// in the front-end hold register before it is queued; the input waits meanwhile.
// Registers: 0x0 near_window, 0x4 min_distance, 0x8 max_best_hits.
module best_hit_tracker_table #(
	parameter int unsigned ENTRY_COUNT = bht_pkg::ENTRY_COUNT
) (
	input  logic        clk,
	input  logic        arst_n,

	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	// [11:0] fragment_index, [17:12] hit_distance, [33:18] reference_id,
	// [34] reverse_strand, [66:35] hit_position, [71:67] zero
	input  logic [71:0] s_tdata,
	// [0] action
	input  logic        s_tuser,

	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	// [6:0] best_distance, [17:7] best_count, [18] entry_enabled, [23:19] zero
	output logic [23:0] m_tdata,

	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	bht_pkg::cfg_t         cfg_q;
	bht_pkg::item_t        in_item;
	bht_pkg::item_t        q_item;
	bht_pkg::back_status_t status;
	logic                  q_valid;
	logic                  q_pop;
	logic                  cfg_we;
	logic [bht_pkg::BEST_W-1:0]  out_best;
	logic [bht_pkg::COUNT_W-1:0] out_count;
	logic                  out_enabled;

	// register file
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.near_window   <= bht_pkg::NEAR_WINDOW_RST;
			cfg_q.min_distance  <= bht_pkg::MIN_DISTANCE_RST;
			cfg_q.max_best_hits <= bht_pkg::MAX_BEST_HITS_RST;
		end else if (cfg_we) begin
			case (paddr[3:2])
				bht_pkg::REG_NEAR_WINDOW:   cfg_q.near_window   <= pwdata[7:0];
				bht_pkg::REG_MIN_DISTANCE:  cfg_q.min_distance  <= pwdata[5:0];
				bht_pkg::REG_MAX_BEST_HITS: cfg_q.max_best_hits <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			bht_pkg::REG_NEAR_WINDOW:   prdata = {24'd0, cfg_q.near_window};
			bht_pkg::REG_MIN_DISTANCE:  prdata = {26'd0, cfg_q.min_distance};
			bht_pkg::REG_MAX_BEST_HITS: prdata = {22'd0, cfg_q.max_best_hits};
			default:                    prdata = '0;
		endcase
	end

	// unpack the input item
	assign in_item.action         = s_tuser;
	assign in_item.fragment_index = s_tdata[11:0];
	assign in_item.hit_distance   = s_tdata[17:12];
	assign in_item.reference_id   = s_tdata[33:18];
	assign in_item.reverse_strand = s_tdata[34];
	assign in_item.hit_position   = s_tdata[66:35];

	bht_front #(
		.ENTRY_COUNT(ENTRY_COUNT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.enable   (!status.clearing),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	bht_back #(
		.ENTRY_COUNT(ENTRY_COUNT)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_best    (out_best),
		.out_count   (out_count),
		.out_enabled (out_enabled),
		.status      (status)
	);

	assign m_tdata = {5'd0, out_enabled, out_count, out_best};

	// nothing enters while the table is being swept
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		status.clearing |-> !s_tready)
		else $error("item accepted during clearing pass");

	// no result can be pending during the sweep
	a_no_result_clear: assert property (@(posedge clk) disable iff (!arst_n)
		status.clearing |-> !m_tvalid)
		else $error("result shown during clearing pass");

	// an entry without a best hit has no count and is enabled
	a_empty_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[6:0] == 7'h7F) |-> (m_tdata[17:7] == 11'd0 && m_tdata[18]))
		else $error("entry without best hit has count or is disabled");

	// count never passes its ceiling
	a_count_ceiling: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[17:7] <= bht_pkg::COUNT_CEILING))
		else $error("best count above ceiling");

endmodule

// ===== tb/tb_best_hit_tracker_table.sv =====
`timescale 1ns / 1ps

module tb_best_hit_tracker_table;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int POOL_SIZE      = 8;
	localparam int COUNT_TOP      = 1024;
	localparam int ENTRIES        = int'(bht_pkg::ENTRY_COUNT);

	// statistics returned for one entry
	typedef struct packed {
		logic [6:0]  best_distance;
		logic [10:0] best_count;
		logic        entry_enabled;
	} entry_stats_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// [11:0] fragment_index, [17:12] hit_distance, [33:18] reference_id,
	// [34] reverse_strand, [66:35] hit_position, [71:67] zero
	logic [71:0] s_tdata;
	// [0] action
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	// [6:0] best_distance, [17:7] best_count, [18] entry_enabled, [23:19] zero
	logic [23:0] m_tdata;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	best_hit_tracker_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// shadow of the fragment table and its registers
	int          frag_best     [ENTRIES];
	int          frag_count    [ENTRIES];
	bit          frag_enabled  [ENTRIES];
	bit          frag_strand   [ENTRIES];
	int          frag_ref_id   [ENTRIES];
	longint      frag_pos      [ENTRIES];
	logic [7:0]  cfg_near_window;
	logic [5:0]  cfg_min_distance;
	logic [9:0]  cfg_max_best_hits;

	entry_stats_t stats_due[$];
	int          frag_pool[POOL_SIZE];
	int          sender_gap_max;
	int          sink_gap_max;
	int          error_count;
	int          idle_cycles;
	int          items_sent;
	int          match_events;
	int          reads_sent;
	int          results_checked;
	int          settings_written;
	int          entries_disabled;

	// clock
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// applies one item to the shadow table and returns the entry afterwards
	function automatic entry_stats_t predict_entry_stats(bht_pkg::item_t it);
		int           e;
		longint       pos_delta;
		bit           too_close;
		entry_stats_t res;
		e = int'(it.fragment_index) % ENTRIES;
		if (it.action == bht_pkg::ACT_MATCH && frag_enabled[e]) begin
			if (int'(it.hit_distance) == frag_best[e]) begin
				pos_delta = longint'({32'd0, it.hit_position}) - frag_pos[e];
				too_close = frag_ref_id[e] == int'(it.reference_id) &&
					frag_strand[e] == it.reverse_strand &&
					pos_delta < longint'({56'd0, cfg_near_window});
				if (!too_close) begin
					if (frag_count[e] < COUNT_TOP)
						frag_count[e]++;
					if (frag_count[e] > int'(cfg_max_best_hits)) begin
						frag_enabled[e] = 1'b0;
						entries_disabled++;
					end
					frag_strand[e] = it.reverse_strand;
					frag_ref_id[e] = int'(it.reference_id);
					frag_pos[e]    = longint'({32'd0, it.hit_position});
				end
			end else if (frag_best[e] == -1 || int'(it.hit_distance) < frag_best[e]) begin
				frag_best[e]  = int'(it.hit_distance);
				frag_count[e] = 1;
				if (it.hit_distance < cfg_min_distance) begin
					frag_enabled[e] = 1'b0;
					entries_disabled++;
				end
				frag_strand[e] = it.reverse_strand;
				frag_ref_id[e] = int'(it.reference_id);
				frag_pos[e]    = longint'({32'd0, it.hit_position});
			end
		end
		res.best_distance = frag_best[e][6:0];
		res.best_count    = frag_count[e][10:0];
		res.entry_enabled = frag_enabled[e];
		return res;
	endfunction

	function automatic bht_pkg::item_t make_item(logic act, int frag, int dist_val,
		int ref_id, logic strand, logic [31:0] pos);
		bht_pkg::item_t it;
		it.action         = act;
		it.fragment_index = 12'(frag);
		it.hit_distance   = 6'(dist_val);
		it.reference_id   = 16'(ref_id);
		it.reverse_strand = strand;
		it.hit_position   = pos;
		return it;
	endfunction

	// mostly events aimed at a few entries, close to their last counted hit
	function automatic bht_pkg::item_t random_item();
		bht_pkg::item_t it;
		int          e;
		int          pick;
		int          dist_pick;
		int          offset;
		logic [31:0] base;
		e    = ($urandom_range(0, 9) < 8) ? frag_pool[$urandom_range(0, POOL_SIZE - 1)]
			: int'($urandom_range(0, ENTRIES - 1));
		pick = $urandom_range(0, 9);
		if (frag_best[e] < 0 || pick >= 8)
			dist_pick = $urandom_range(0, 63);
		else if (pick < 5)
			dist_pick = frag_best[e];
		else if (pick < 7)
			dist_pick = (frag_best[e] > 3) ? frag_best[e] - int'($urandom_range(1, 3)) : 0;
		else
			dist_pick = (frag_best[e] < 60) ? frag_best[e] + int'($urandom_range(1, 3)) : 63;
		it = make_item(($urandom_range(0, 9) == 0) ? bht_pkg::ACT_READ : bht_pkg::ACT_MATCH,
			e, dist_pick, int'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
			$urandom());
		if (frag_best[e] >= 0) begin
			if ($urandom_range(0, 9) < 7)
				it.reference_id = 16'(frag_ref_id[e]);
			if ($urandom_range(0, 9) < 7)
				it.reverse_strand = frag_strand[e];
			if ($urandom_range(0, 9) < 6) begin
				base   = frag_pos[e][31:0];
				offset = int'($urandom_range(0, 2 * cfg_near_window + 8)) - 4;
				it.hit_position = base + offset;
			end
		end
		return it;
	endfunction

	function automatic logic [31:0] register_value(logic [1:0] idx);
		case (idx)
			bht_pkg::REG_NEAR_WINDOW:   return {24'd0, cfg_near_window};
			bht_pkg::REG_MIN_DISTANCE:  return {26'd0, cfg_min_distance};
			bht_pkg::REG_MAX_BEST_HITS: return {22'd0, cfg_max_best_hits};
			default:                    return 32'd0;
		endcase
	endfunction

	// one item on the input stream; the gap is drawn per item
	task automatic send_item(bht_pkg::item_t it);
		int gap;
		gap = $urandom_range(0, sender_gap_max);
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= it.action;
		s_tdata  <= {5'd0, it.hit_position, it.reverse_strand, it.reference_id,
			it.hit_distance, it.fragment_index};
		do @(posedge clk); while (!s_tready);
		stats_due.push_back(predict_entry_stats(it));
		items_sent++;
		if (it.action == bht_pkg::ACT_MATCH)
			match_events++;
		else
			reads_sent++;
	endtask

	// stop sending and let every expected result come back
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (stats_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// register read, compared with the shadow value
	task automatic check_register(logic [1:0] idx);
		logic [31:0] got;
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b0;
		penable <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got !== register_value(idx)) begin
			$error("register %0d: expected %0d, got %0d", idx, register_value(idx), got);
			error_count++;
		end
	endtask

	task automatic write_register(logic [1:0] idx, logic [31:0] value);
		drain_results();
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			bht_pkg::REG_NEAR_WINDOW:   cfg_near_window   = value[7:0];
			bht_pkg::REG_MIN_DISTANCE:  cfg_min_distance  = value[5:0];
			bht_pkg::REG_MAX_BEST_HITS: cfg_max_best_hits = value[9:0];
			default: ;
		endcase
		settings_written++;
		check_register(idx);
	endtask

	task automatic set_config(int window, int min_dist, int max_hits);
		write_register(bht_pkg::REG_NEAR_WINDOW, window);
		write_register(bht_pkg::REG_MIN_DISTANCE, min_dist);
		write_register(bht_pkg::REG_MAX_BEST_HITS, max_hits);
	endtask

	// untouched entries and register reset values
	task automatic test_reset_state();
		check_register(bht_pkg::REG_NEAR_WINDOW);
		check_register(bht_pkg::REG_MIN_DISTANCE);
		check_register(bht_pkg::REG_MAX_BEST_HITS);
		send_item(make_item(bht_pkg::ACT_READ, 0, 63, 16'hFFFF, 1'b1, 32'hFFFF_FFFF));
		send_item(make_item(bht_pkg::ACT_READ, ENTRIES - 1, 0, 0, 1'b0, 32'd0));
	endtask

	// equal, better and worse distances, window skips, disabling
	task automatic test_match_rules();
		send_item(make_item(bht_pkg::ACT_MATCH, 5, 10, 16'hFFFF, 1'b1, 32'd1000));
		send_item(make_item(bht_pkg::ACT_MATCH, 5, 10, 16'hFFFF, 1'b1, 32'd1017)); // too close
		send_item(make_item(bht_pkg::ACT_MATCH, 5, 10, 16'hFFFF, 1'b1, 32'd999));  // behind
		send_item(make_item(bht_pkg::ACT_MATCH, 5, 10, 16'hFFFF, 1'b1, 32'd1018)); // counted
		send_item(make_item(bht_pkg::ACT_MATCH, 5, 10, 16'hFFFF, 1'b0, 32'd1018)); // other strand
		send_item(make_item(bht_pkg::ACT_MATCH, 5, 10, 16'h0000, 1'b0, 32'd1018)); // other ref
		send_item(make_item(bht_pkg::ACT_MATCH, 5, 20, 16'h0000, 1'b0, 32'd5000)); // worse
		send_item(make_item(bht_pkg::ACT_MATCH, 5, 3, 16'h0000, 1'b0, 32'd5000));  // better
		send_item(make_item(bht_pkg::ACT_MATCH, 5, 0, 16'h0000, 1'b0, 32'd5000));  // below min
		send_item(make_item(bht_pkg::ACT_MATCH, 5, 0, 16'h1234, 1'b1, 32'd9000));  // disabled
		send_item(make_item(bht_pkg::ACT_MATCH, ENTRIES - 1, 63, 0, 1'b0, 32'd0));
		send_item(make_item(bht_pkg::ACT_MATCH, ENTRIES - 1, 63, 16'hFFFF, 1'b1,
			32'hFFFF_FFFF));
		send_item(make_item(bht_pkg::ACT_READ, ENTRIES - 1, 0, 0, 1'b0, 32'd0));
	endtask

	// count limit of zero, window of zero, minimum at its top
	task automatic test_register_extremes();
		set_config(18, 2, 0);
		send_item(make_item(bht_pkg::ACT_MATCH, 7, 5, 1, 1'b0, 32'd0));
		send_item(make_item(bht_pkg::ACT_MATCH, 7, 5, 2, 1'b0, 32'd0)); // exceeds limit
		set_config(0, 0, 10);
		send_item(make_item(bht_pkg::ACT_MATCH, 8, 4, 1, 1'b0, 32'd100));
		send_item(make_item(bht_pkg::ACT_MATCH, 8, 4, 1, 1'b0, 32'd100)); // same place, counted
		send_item(make_item(bht_pkg::ACT_MATCH, 8, 4, 1, 1'b0, 32'd99));  // behind, skipped
		set_config(0, 63, 10);
		send_item(make_item(bht_pkg::ACT_MATCH, 9, 62, 1, 1'b0, 32'd7));  // below minimum
	endtask

	// one entry hammered until its count reaches the ceiling
	task automatic test_count_ceiling();
		set_config(1, 0, 1023);
		while (frag_enabled[12'h800])
			send_item(make_item(bht_pkg::ACT_MATCH, 12'h800, 63,
				int'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)), $urandom()));
		repeat (2)
			send_item(make_item(bht_pkg::ACT_MATCH, 12'h800, 63, 3, 1'b1, $urandom()));
		send_item(make_item(bht_pkg::ACT_READ, 12'h800, 0, 0, 1'b0, 32'd0));
	endtask

	task automatic test_random_traffic();
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0:       set_config(255, 0, 1023);
				1:       set_config(0, 63, 0);
				default: set_config($urandom_range(0, 255), $urandom_range(0, 63),
					$urandom_range(0, 1023));
			endcase
			for (int i = 0; i < POOL_SIZE; i++)
				frag_pool[i] = $urandom_range(0, ENTRIES - 1);
			frag_pool[0] = (phase == 0) ? 0 : frag_pool[0];
			frag_pool[1] = (phase == 1) ? ENTRIES - 1 : frag_pool[1];
			for (int n = 0; n < 60; n++) begin
				if (n % 20 == 0) begin
					sender_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 19;
					sink_gap_max   = ($urandom_range(0, 2) == 0) ? 0 : 19;
				end
				if (phase == 2 && n == 30)
					drain_results();
				send_item(random_item());
			end
		end
		sender_gap_max = 19;
		sink_gap_max   = 19;
	endtask

	// result side: random stalls, drawn per result
	initial begin
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = $urandom_range(0, sink_gap_max);
			@(negedge clk);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	// result checker
	always @(posedge clk) begin
		entry_stats_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (stats_due.size() == 0) begin
				$error("result with no item outstanding: %h", m_tdata);
				error_count++;
			end else begin
				want = stats_due.pop_front();
				results_checked++;
				if (m_tdata[6:0] !== want.best_distance) begin
					$error("best_distance: expected %0d, got %0d",
						$signed(want.best_distance), $signed(m_tdata[6:0]));
					error_count++;
				end
				if (m_tdata[17:7] !== want.best_count) begin
					$error("best_count: expected %0d, got %0d", want.best_count,
						m_tdata[17:7]);
					error_count++;
				end
				if (m_tdata[18] !== want.entry_enabled) begin
					$error("entry_enabled: expected %0d, got %0d", want.entry_enabled,
						m_tdata[18]);
					error_count++;
				end
			end
		end
	end

	// watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = bht_pkg::ACT_MATCH;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		sender_gap_max   = 19;
		sink_gap_max     = 19;
		error_count      = 0;
		idle_cycles      = 0;
		items_sent       = 0;
		match_events     = 0;
		reads_sent       = 0;
		results_checked  = 0;
		settings_written = 0;
		entries_disabled = 0;
		for (int i = 0; i < ENTRIES; i++) begin
			frag_best[i]    = -1;
			frag_count[i]   = 0;
			frag_enabled[i] = 1'b1;
			frag_strand[i]  = 1'b0;
			frag_ref_id[i]  = -1;
			frag_pos[i]     = -1;
		end
		cfg_near_window   = bht_pkg::NEAR_WINDOW_RST;
		cfg_min_distance  = bht_pkg::MIN_DISTANCE_RST;
		cfg_max_best_hits = bht_pkg::MAX_BEST_HITS_RST;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_match_rules();
		test_register_extremes();
		test_count_ceiling();
		test_random_traffic();

		drain_results();
		repeat (8) @(posedge clk);
		$display("Sent %0d items (%0d match events, %0d reads), checked %0d results;",
			items_sent, match_events, reads_sent, results_checked);
		$display("%0d register writes, %0d entries disabled, count ceiling reached once.",
			settings_written, entries_disabled);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
